// ----- rtl/iehk_pkg.sv -----
`timescale 1ns / 1ps

package iehk_pkg;

	localparam int HOTKEY_COUNT = 128;
	localparam int HK_IDX_W     = 7;
	localparam int KEY_BITS     = 256;
	localparam int BTN_BITS     = 5;
	localparam int ROW_W        = KEY_BITS + BTN_BITS;
	localparam int ACC_W        = 32;
	localparam int MOVE_W       = 16;

	localparam int CMD_W        = 4;
	localparam int IN_DATA_W    = 80;
	localparam int OUT_DATA_W   = 72;
	localparam int CFG_DATA_W   = 8;

	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

	localparam logic [HK_IDX_W:0] HK_LIMIT = (HK_IDX_W + 1)'(HOTKEY_COUNT);

	localparam logic [CMD_W-1:0] CMD_MOUSE      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_KEY        = 4'd1;
	localparam logic [CMD_W-1:0] CMD_FETCH      = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DOWN       = 4'd3;
	localparam logic [CMD_W-1:0] CMD_PRESSED    = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RELEASED   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_BIND_CLEAR = 4'd6;
	localparam logic [CMD_W-1:0] CMD_BIND_ADD   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RESET_KEYS = 4'd8;
	localparam logic [CMD_W-1:0] CMD_CLEAR_BIND = 4'd9;
	localparam logic [CMD_W-1:0] CMD_DISCARD    = 4'd10;
	localparam logic [CMD_W-1:0] CMD_BTN_RESET  = 4'd11;

	localparam logic [0:0] CFG_LSHIFT = 1'd0;
	localparam logic [0:0] CFG_RSHIFT = 1'd1;

	localparam logic [7:0] CFG_LSHIFT_RST = 8'd42;
	localparam logic [7:0] CFG_RSHIFT_RST = 8'd54;

	localparam logic [7:0] VK_NONE     = 8'h00;
	localparam logic [7:0] VK_INVALID  = 8'hFF;
	localparam logic [7:0] MOD_SHIFT   = 8'h10;
	localparam logic [7:0] VK_CTRL     = 8'h11;
	localparam logic [7:0] VK_ALT      = 8'h12;
	localparam logic [7:0] MOD_SHIFT_L = 8'hA0;
	localparam logic [7:0] MOD_SHIFT_R = 8'hA1;
	localparam logic [7:0] VK_LCTRL    = 8'hA2;
	localparam logic [7:0] VK_RCTRL    = 8'hA3;
	localparam logic [7:0] VK_LALT     = 8'hA4;
	localparam logic [7:0] VK_RALT     = 8'hA5;

	localparam logic [7:0] BIND_BTN0 = 8'd1;
	localparam logic [7:0] BIND_BTN1 = 8'd2;
	localparam logic [7:0] BIND_NOP  = 8'd3;
	localparam logic [7:0] BIND_BTN2 = 8'd4;
	localparam logic [7:0] BIND_BTN3 = 8'd5;
	localparam logic [7:0] BIND_BTN4 = 8'd6;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [MOVE_W-1:0]   move_x;
		logic [MOVE_W-1:0]   move_y;
		logic                move_en;
		logic [BTN_BITS-1:0] btn_dn;
		logic [BTN_BITS-1:0] btn_up;
		logic                key_en;
		logic [7:0]          key_code;
		logic                key_break;
		logic [HK_IDX_W-1:0] id;
		logic                id_ok;
		logic [BTN_BITS-1:0] bind_btn;
		logic                bind_key_en;
		logic [7:0]          bind_key;
	} item_t;

endpackage

// ----- rtl/iehk_front.sv -----
`timescale 1ns / 1ps

module iehk_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [iehk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [iehk_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [iehk_pkg::CMD_W-1:0]     s_tuser,
	output logic                           push_valid,
	input  logic                           push_ready,
	output iehk_pkg::item_t                push_item
);
	import iehk_pkg::*;

	logic [7:0] lshift_q;
	logic [7:0] rshift_q;

	logic [7:0]    vkey;
	logic [7:0]    make_code;
	logic          key_e0;
	logic [9:0]    flags;
	logic [7:0]    bvk;
	logic [7:0]    side_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lshift_q <= CFG_LSHIFT_RST;
			rshift_q <= CFG_RSHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LSHIFT: lshift_q <= cfg_data;
				CFG_RSHIFT: rshift_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vkey      = s_tdata[50:43];
	assign make_code = s_tdata[58:51];
	assign key_e0    = s_tdata[60];
	assign flags     = s_tdata[42:33];
	assign bvk       = s_tdata[75:68];

	// map generic modifiers to their left or right key
	always_comb begin
		case (vkey)
			MOD_SHIFT: begin
				if (make_code == lshift_q)
					side_code = MOD_SHIFT_L;
				else if (make_code == rshift_q)
					side_code = MOD_SHIFT_R;
				else
					side_code = MOD_SHIFT_L;
			end
			VK_CTRL: side_code = key_e0 ? VK_RCTRL : VK_LCTRL;
			VK_ALT:  side_code = key_e0 ? VK_RALT : VK_LALT;
			default: side_code = vkey;
		endcase
	end

	always_comb begin
		push_item           = '0;
		push_item.cmd       = s_tuser;
		push_item.move_x    = s_tdata[15:0];
		push_item.move_y    = s_tdata[31:16];
		push_item.move_en   = !s_tdata[32];
		for (int b = 0; b < BTN_BITS; b++) begin
			push_item.btn_dn[b] = flags[2*b];
			push_item.btn_up[b] = flags[2*b+1];
		end
		push_item.key_en    = (vkey != VK_NONE) && (vkey != VK_INVALID);
		push_item.key_code  = side_code;
		push_item.key_break = s_tdata[59];
		push_item.id        = s_tdata[67:61];
		push_item.id_ok     = {1'b0, s_tdata[67:61]} < HK_LIMIT;
		case (bvk)
			BIND_BTN0: push_item.bind_btn = 5'b00001;
			BIND_BTN1: push_item.bind_btn = 5'b00010;
			BIND_BTN2: push_item.bind_btn = 5'b00100;
			BIND_BTN3: push_item.bind_btn = 5'b01000;
			BIND_BTN4: push_item.bind_btn = 5'b10000;
			BIND_NOP:  push_item.bind_btn = 5'b00000;
			default:   push_item.bind_key_en = 1'b1;
		endcase
		push_item.bind_key  = bvk;
	end

	assign push_valid = s_tvalid;
	assign s_tready   = push_ready;

endmodule

// ----- rtl/iehk_fifo.sv -----
`timescale 1ns / 1ps

module iehk_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  iehk_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop,
	output iehk_pkg::item_t pop_item
);
	import iehk_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  push_fire;
	logic                  pop_fire;

	assign push_ready = count_q != (FIFO_PTR_W + 1)'(FIFO_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop && pop_valid;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_fire)
			mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_fire)
				wr_q <= wr_q + 1'b1;
			if (pop_fire)
				rd_q <= rd_q + 1'b1;
			case ({push_fire, pop_fire})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_fifo_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill count did not advance on push");
`endif

endmodule

// ----- rtl/iehk_back.sv -----
`timescale 1ns / 1ps

module iehk_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop,
	input  iehk_pkg::item_t                 pop_item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [iehk_pkg::OUT_DATA_W-1:0] m_tdata
);
	import iehk_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                    state_q;
	item_t                   cur_q;
	logic [ROW_W-1:0]        mem [HOTKEY_COUNT];
	logic [ROW_W-1:0]        rd_q;
	logic [KEY_BITS-1:0]     keymap_q;
	logic [BTN_BITS-1:0]     buttons_q;
	logic [ACC_W-1:0]        acc_x_q;
	logic [ACC_W-1:0]        acc_y_q;
	logic [HOTKEY_COUNT-1:0] valid_q;
	logic [HOTKEY_COUNT-1:0] prev_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic                    out_free;
	logic                    exec_fire;
	logic [KEY_BITS-1:0]     row_keys;
	logic [BTN_BITS-1:0]     row_btn;
	logic                    hit;
	logic                    prev;
	logic [BTN_BITS-1:0]     buttons_nx;
	logic                    answer;
	logic [ACC_W-1:0]        res_x;
	logic [ACC_W-1:0]        res_y;
	logic                    mem_we;
	logic [ROW_W-1:0]        mem_wd;
	logic [KEY_BITS-1:0]     bind_bit;

	assign out_free  = !out_valid_q || m_tready;
	assign pop       = (state_q == ST_IDLE) && pop_valid;
	assign exec_fire = (state_q == ST_EXEC) && out_free;

	// an unbound entry reads as all-zero masks
	assign row_keys = valid_q[cur_q.id] ? rd_q[KEY_BITS-1:0] : '0;
	assign row_btn  = valid_q[cur_q.id] ? rd_q[ROW_W-1:KEY_BITS] : '0;
	assign hit      = ((row_keys & keymap_q) != '0) || ((row_btn & buttons_q) != '0);
	assign prev     = prev_q[cur_q.id];
	assign bind_bit = cur_q.bind_key_en ? (KEY_BITS'(1) << cur_q.bind_key) : '0;
	assign mem_we   = exec_fire && (cur_q.cmd == CMD_BIND_ADD) && cur_q.id_ok;
	assign mem_wd   = {row_btn | cur_q.bind_btn, row_keys | bind_bit};

	always_comb begin
		buttons_nx = buttons_q;
		answer     = 1'b0;
		res_x      = '0;
		res_y      = '0;
		case (cur_q.cmd)
			CMD_MOUSE:      buttons_nx = (buttons_q | cur_q.btn_dn) & ~cur_q.btn_up;
			CMD_FETCH: begin
				res_x = acc_x_q;
				res_y = acc_y_q;
			end
			CMD_DOWN:       answer = cur_q.id_ok && hit;
			CMD_PRESSED:    answer = cur_q.id_ok && hit && !prev;
			CMD_RELEASED:   answer = cur_q.id_ok && !hit && prev;
			CMD_RESET_KEYS: buttons_nx = '0;
			CMD_BTN_RESET:  buttons_nx = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[cur_q.id] <= mem_wd;
		if (pop)
			rd_q <= mem[pop_item.id];
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= pop_item;
		if (exec_fire)
			out_data_q <= {(OUT_DATA_W - 2*ACC_W - 1 - BTN_BITS)'(0),
				buttons_nx, answer, res_y, res_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			keymap_q    <= '0;
			buttons_q   <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			valid_q     <= '0;
			prev_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (pop) state_q <= ST_EXEC;
				ST_EXEC: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase

			if (exec_fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (exec_fire) begin
				buttons_q <= buttons_nx;
				case (cur_q.cmd)
					CMD_MOUSE: begin
						if (cur_q.move_en) begin
							acc_x_q <= acc_x_q + {{(ACC_W-MOVE_W){cur_q.move_x[MOVE_W-1]}},
								cur_q.move_x};
							acc_y_q <= acc_y_q + {{(ACC_W-MOVE_W){cur_q.move_y[MOVE_W-1]}},
								cur_q.move_y};
						end
					end
					CMD_KEY: begin
						if (cur_q.key_en)
							keymap_q[cur_q.key_code] <= !cur_q.key_break;
					end
					CMD_FETCH, CMD_DISCARD: begin
						acc_x_q <= '0;
						acc_y_q <= '0;
					end
					CMD_PRESSED, CMD_RELEASED: begin
						if (cur_q.id_ok)
							prev_q[cur_q.id] <= hit;
					end
					CMD_BIND_CLEAR: begin
						if (cur_q.id_ok)
							valid_q[cur_q.id] <= 1'b0;
					end
					CMD_BIND_ADD: begin
						if (cur_q.id_ok)
							valid_q[cur_q.id] <= 1'b1;
					end
					CMD_RESET_KEYS: begin
						keymap_q <= '0;
						prev_q   <= '0;
					end
					CMD_CLEAR_BIND: begin
						valid_q <= '0;
						prev_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTH
	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_EXEC))
		else $error("request popped without moving to execute");
	a_reset_keys: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && cur_q.cmd == CMD_RESET_KEYS) |=>
		(keymap_q == '0 && buttons_q == '0 && prev_q == '0))
		else $error("key state not cleared by reset keys");
	a_fetch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_fire && cur_q.cmd == CMD_FETCH) |=> (acc_x_q == '0 && acc_y_q == '0))
		else $error("motion accumulators not cleared by fetch");
`endif

endmodule

// ----- rtl/input_event_hotkey_tracker_top.sv -----
`timescale 1ns / 1ps

// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------
// s        | s_tvalid / s_tready | s_tuser cmd, s_tdata event and query fields
// m        | m_tvalid / m_tready | m_tdata motion, hotkey answer, buttons
// cfg      | cfg_we              | cfg_index, cfg_data (shift scancodes)
//
// In the execute unit a request and its binding table row are registered
// first; it is then evaluated and loaded into the output register once that
// register is free. A 2-entry queue sits between the decoder and the execute
// unit; while a result waits on m_tready, the input side takes up to three more
// requests. Reset (arst_n) clears key, button, motion, bound, edge state at once.

module input_event_hotkey_tracker_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [iehk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// move_x, move_y, absolute_move, button_flags, vkey, make_code,
	// key_break, key_e0, hotkey_id, bind_vkey, zero pad
	input  logic [iehk_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [iehk_pkg::CMD_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// motion_x, motion_y, hotkey_answer, button_state, zero pad
	output logic [iehk_pkg::OUT_DATA_W-1:0] m_tdata
);
	import iehk_pkg::*;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop;
	item_t pop_item;

	iehk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	iehk_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	iehk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
